>>> sv/multigrid_restrict_2d_defines.svh
// Assertion macros for the 2D multigrid restriction block.
// Used by the top level only; depends on nothing else.
`ifndef MULTIGRID_RESTRICT_2D_DEFINES_SVH
`define MULTIGRID_RESTRICT_2D_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define MGR2D_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// Next-cycle implication, disabled while reset is high.
`define MGR2D_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

>>> sv/mgr2d_pkg.sv
// Shared types, sizes and helpers for the 2D multigrid restriction block.
// Used by every module of the block; depends on nothing.
package mgr2d_pkg;

   localparam int MAX_COARSE_WIDTH  = 512;
   localparam int MAX_COARSE_HEIGHT = 4096;
   localparam int SAMPLE_BITS       = 32;

   // Register field widths are fixed by the register map.
   localparam int WIDTH_REG_BITS  = 10;
   localparam int HEIGHT_REG_BITS = 13;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_COARSE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COARSE_HEIGHT = 2'd1;

   // Position counter widths follow from the largest grid.
   localparam int CW_M1_BITS = (MAX_COARSE_WIDTH > 1) ? $clog2(MAX_COARSE_WIDTH) : 1;
   localparam int COL_BITS   = CW_M1_BITS + 1;
   localparam int CH_M1_BITS = $clog2(MAX_COARSE_HEIGHT);
   localparam int ROW_BITS   = CH_M1_BITS + 1;
   localparam int LINE_DEPTH = 2 * MAX_COARSE_WIDTH;
   localparam int LINE_SLOTS = 3;

   localparam int RESET_COARSE   = 512;
   localparam int WIDTH_RESET_M1 =
      ((RESET_COARSE > MAX_COARSE_WIDTH) ? MAX_COARSE_WIDTH : RESET_COARSE) - 1;
   localparam int HEIGHT_RESET_M1 =
      ((RESET_COARSE > MAX_COARSE_HEIGHT) ? MAX_COARSE_HEIGHT : RESET_COARSE) - 1;

   // A vertical sum is eight samples wide, the full sum sixty-four.
   localparam int V_BITS     = SAMPLE_BITS + 3;
   localparam int H_BITS     = SAMPLE_BITS + 6;
   localparam int ROUND_BIAS = 32;
   localparam int FRAC_SHIFT = 6;

   localparam int MID_DEPTH    = 4;
   localparam int MID_PTR_BITS = $clog2(MID_DEPTH);
   localparam int MID_CNT_BITS = MID_PTR_BITS + 1;
   localparam int OUT_DEPTH    = 8;
   localparam int OUT_PTR_BITS = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_BITS = OUT_PTR_BITS + 1;

   localparam logic [1:0] FIRST_SLOT = 2'd0;
   localparam logic [1:0] LAST_SLOT  = 2'd2;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [V_BITS-1:0]      vsum_type;
   typedef logic signed [H_BITS-1:0]      hsum_type;

   // One classified fine sample, handed from the front end to the back end.
   typedef struct packed {
      sample_type          sample;
      logic [COL_BITS-1:0] col;
      logic [1:0]          slot;
      logic                row_emit;
      logic                row_last;
      logic                row_far;
      logic                col_emit;
      logic                col_last;
      logic                col_far;
      logic                frame_end;
   } desc_type;

   typedef struct packed {
      sample_type sample;
      logic       row_end;
      logic       frame_end;
   } rsp_word_type;

   typedef struct packed {
      logic [COL_BITS-1:0] col;
      logic [ROW_BITS-1:0] row;
   } front_status_type;

   typedef struct packed {
      logic [OUT_CNT_BITS-1:0] out_count;
      logic [1:0]              inflight;
   } back_status_type;

   // Line buffer slot that holds the row before the one in slot s.
   function automatic logic [1:0] slot_prev(input logic [1:0] s);
      return (s == FIRST_SLOT) ? LAST_SLOT : s - 2'd1;
   endfunction

   function automatic logic [1:0] slot_next(input logic [1:0] s);
      return (s == LAST_SLOT) ? FIRST_SLOT : s + 2'd1;
   endfunction

endpackage

>>> sv/mgr2d_front.sv
// Front end: configuration registers, fine grid position counters and
// classification of each accepted word. Depends on mgr2d_pkg.
module mgr2d_front import mgr2d_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   input  sample_type                req_fine_sample,
   output logic                      req_full,
   input  logic                      csr_valid,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output logic                      csr_ready,
   output logic                      desc_push,
   output desc_type                  desc,
   input  logic                      desc_full,
   output front_status_type          status
);

   logic [COL_BITS-1:0]       col_ff, col_in;
   logic [ROW_BITS-1:0]       row_ff, row_in;
   logic [1:0]                slot_ff, slot_in;
   logic [CW_M1_BITS-1:0]     width_m1_ff, width_m1_in;
   logic [CH_M1_BITS-1:0]     height_m1_ff, height_m1_in;
   logic [WIDTH_REG_BITS-1:0] wval;
   logic [HEIGHT_REG_BITS-1:0] hval;
   logic                      accept;
   logic                      restart;
   logic                      col_last, row_last;

   assign csr_ready = 1'b1;
   assign req_full  = desc_full;
   assign accept    = req_push && !desc_full;
   assign desc_push = accept;

   assign col_last = (col_ff == {width_m1_ff, 1'b1});
   assign row_last = (row_ff == {height_m1_ff, 1'b1});

   always_comb begin
      desc.sample    = req_fine_sample;
      desc.col       = col_ff;
      desc.slot      = slot_ff;
      desc.row_last  = row_last;
      desc.row_far   = (row_ff >= ROW_BITS'(3));
      desc.row_emit  = (!row_ff[0] && (row_ff[ROW_BITS-1:1] != '0)) || row_last;
      desc.col_last  = col_last;
      desc.col_far   = (col_ff >= COL_BITS'(3));
      desc.col_emit  = (!col_ff[0] && (col_ff[COL_BITS-1:1] != '0)) || col_last;
      desc.frame_end = col_last && row_last;
   end

   // Register writes clamp the size into range and restart the frame.
   always_comb begin
      wval         = csr_wdata[WIDTH_REG_BITS-1:0];
      hval         = csr_wdata[HEIGHT_REG_BITS-1:0];
      width_m1_in  = width_m1_ff;
      height_m1_in = height_m1_ff;
      restart      = 1'b0;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_COARSE_WIDTH: begin
               restart = 1'b1;
               if (wval == '0) begin
                  width_m1_in = '0;
               end else if (32'(wval) > MAX_COARSE_WIDTH) begin
                  width_m1_in = CW_M1_BITS'(MAX_COARSE_WIDTH - 1);
               end else begin
                  width_m1_in = CW_M1_BITS'(wval - 1'b1);
               end
            end
            CSR_COARSE_HEIGHT: begin
               restart = 1'b1;
               if (hval == '0) begin
                  height_m1_in = '0;
               end else if (32'(hval) > MAX_COARSE_HEIGHT) begin
                  height_m1_in = CH_M1_BITS'(MAX_COARSE_HEIGHT - 1);
               end else begin
                  height_m1_in = CH_M1_BITS'(hval - 1'b1);
               end
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      slot_in = slot_ff;
      if (restart) begin
         col_in  = '0;
         row_in  = '0;
         slot_in = FIRST_SLOT;
      end else if (accept) begin
         if (col_last) begin
            col_in = '0;
            if (row_last) begin
               row_in  = '0;
               slot_in = FIRST_SLOT;
            end else begin
               row_in  = row_ff + 1'b1;
               slot_in = slot_next(slot_ff);
            end
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         slot_ff      <= FIRST_SLOT;
         width_m1_ff  <= CW_M1_BITS'(WIDTH_RESET_M1);
         height_m1_ff <= CH_M1_BITS'(HEIGHT_RESET_M1);
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         slot_ff      <= slot_in;
         width_m1_ff  <= width_m1_in;
         height_m1_ff <= height_m1_in;
      end
   end

   assign status.col = col_ff;
   assign status.row = row_ff;

endmodule

>>> sv/mgr2d_desc_fifo.sv
// Short queue of classified words between the front end and the back end.
// Depends on mgr2d_pkg.
module mgr2d_desc_fifo import mgr2d_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  desc_type                din,
   output logic                    full,
   input  logic                    pop,
   output desc_type                dout,
   output logic                    empty,
   output logic [MID_CNT_BITS-1:0] count
);

   desc_type                entry_ff [MID_DEPTH];
   logic [MID_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [MID_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [MID_CNT_BITS-1:0] count_ff, count_in;
   logic                    do_push, do_pop;

   assign full    = (count_ff == MID_CNT_BITS'(MID_DEPTH));
   assign empty   = (count_ff == '0);
   assign count   = count_ff;
   assign dout    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + MID_CNT_BITS'(do_push) - MID_CNT_BITS'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

>>> sv/mgr2d_back.sv
// Back end: three fine row line buffers, vertical and horizontal 1-3-3-1
// sums, rounding and the result queue. Depends on mgr2d_pkg.
module mgr2d_back import mgr2d_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  desc_type        desc,
   input  logic            desc_empty,
   output logic            desc_pop,
   output sample_type      rsp_coarse_sample,
   output logic            rsp_row_end,
   output logic            rsp_frame_end,
   output logic            rsp_empty,
   input  logic            rsp_pop,
   output back_status_type status
);

   // Stage B: line buffer read data and the word that issued the read.
   logic       b_valid_ff;
   desc_type   b_desc_ff;
   sample_type line_rd_ff [LINE_SLOTS];

   // Stage C: vertical sum of the current column.
   logic     c_valid_ff;
   vsum_type c_v_ff;
   logic     c_emit_ff, c_col_last_ff, c_col_far_ff, c_frame_end_ff;

   // Vertical sums of the three previous columns, newest first.
   vsum_type win0_ff, win1_ff, win2_ff;

   // Stage D: full 4x4 sum of a finished coarse cell.
   logic     d_valid_ff;
   hsum_type d_h_ff;
   logic     d_row_end_ff, d_frame_end_ff;

   rsp_word_type            out_ff [OUT_DEPTH];
   logic [OUT_PTR_BITS-1:0] out_wr_ff, out_rd_ff;
   logic [OUT_CNT_BITS-1:0] out_count_ff, out_count_in;

   logic                    b_emit;
   logic [OUT_CNT_BITS:0]   credit_sum;
   logic                    out_pop;
   sample_type              m1, m2, m3;
   sample_type              va, vp, vq;
   vsum_type                v_sum;
   vsum_type                ha, hp, hq;
   hsum_type                h_sum;
   hsum_type                rounded;

   // A word enters the pipeline only when the result queue has room for
   // every cell already on its way.
   assign b_emit     = b_valid_ff && b_desc_ff.row_emit && b_desc_ff.col_emit;
   assign credit_sum = {1'b0, out_count_ff} + (OUT_CNT_BITS+1)'(b_emit)
                     + (OUT_CNT_BITS+1)'(c_valid_ff && c_emit_ff)
                     + (OUT_CNT_BITS+1)'(d_valid_ff);
   assign desc_pop   = !desc_empty && (credit_sum < (OUT_CNT_BITS+1)'(OUT_DEPTH));

   for (genvar k = 0; k < LINE_SLOTS; k++) begin : g_line
      sample_type mem [LINE_DEPTH];
      always_ff @(posedge clock) begin
         line_rd_ff[k] <= mem[desc.col];
         if (desc_pop && (desc.slot == 2'(k))) begin
            mem[desc.col] <= desc.sample;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= desc_pop;
      end
      b_desc_ff <= desc;
   end

   // The slot being written holds the row three back before the write.
   always_comb begin
      m1 = line_rd_ff[slot_prev(b_desc_ff.slot)];
      m2 = line_rd_ff[slot_prev(slot_prev(b_desc_ff.slot))];
      m3 = line_rd_ff[b_desc_ff.slot];
      if (b_desc_ff.row_last) begin
         va = b_desc_ff.row_far ? m2 : m1;
         vp = m1;
         vq = b_desc_ff.sample;
      end else begin
         va = b_desc_ff.row_far ? m3 : m2;
         vp = m2;
         vq = m1;
      end
      v_sum = V_BITS'(va) + (V_BITS'(vp) <<< 1) + V_BITS'(vp)
            + (V_BITS'(vq) <<< 1) + V_BITS'(vq) + V_BITS'(b_desc_ff.sample);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= b_valid_ff;
      end
      c_v_ff         <= b_desc_ff.row_emit ? v_sum : '0;
      c_emit_ff      <= b_desc_ff.row_emit && b_desc_ff.col_emit;
      c_col_last_ff  <= b_desc_ff.col_last;
      c_col_far_ff   <= b_desc_ff.col_far;
      c_frame_end_ff <= b_desc_ff.frame_end;
   end

   always_comb begin
      if (c_col_last_ff) begin
         ha = c_col_far_ff ? win1_ff : win0_ff;
         hp = win0_ff;
         hq = c_v_ff;
      end else begin
         ha = c_col_far_ff ? win2_ff : win1_ff;
         hp = win1_ff;
         hq = win0_ff;
      end
      h_sum = H_BITS'(ha) + (H_BITS'(hp) <<< 1) + H_BITS'(hp)
            + (H_BITS'(hq) <<< 1) + H_BITS'(hq) + H_BITS'(c_v_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win0_ff    <= '0;
         win1_ff    <= '0;
         win2_ff    <= '0;
         d_valid_ff <= 1'b0;
      end else begin
         if (c_valid_ff) begin
            win0_ff <= c_v_ff;
            win1_ff <= win0_ff;
            win2_ff <= win1_ff;
         end
         d_valid_ff <= c_valid_ff && c_emit_ff;
      end
      d_h_ff         <= h_sum;
      d_row_end_ff   <= c_col_last_ff;
      d_frame_end_ff <= c_frame_end_ff;
   end

   // Divide by 64, rounding half up.
   assign rounded = (d_h_ff + H_BITS'(ROUND_BIAS)) >>> FRAC_SHIFT;

   assign rsp_empty    = (out_count_ff == '0);
   assign out_pop      = rsp_pop && !rsp_empty;
   assign out_count_in = out_count_ff + OUT_CNT_BITS'(d_valid_ff) - OUT_CNT_BITS'(out_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ff    <= '0;
         out_rd_ff    <= '0;
         out_count_ff <= '0;
      end else begin
         if (d_valid_ff) begin
            out_wr_ff <= out_wr_ff + 1'b1;
         end
         if (out_pop) begin
            out_rd_ff <= out_rd_ff + 1'b1;
         end
         out_count_ff <= out_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (d_valid_ff) begin
         out_ff[out_wr_ff].sample    <= rounded[SAMPLE_BITS-1:0];
         out_ff[out_wr_ff].row_end   <= d_row_end_ff;
         out_ff[out_wr_ff].frame_end <= d_frame_end_ff;
      end
   end

   assign rsp_coarse_sample = out_ff[out_rd_ff].sample;
   assign rsp_row_end       = out_ff[out_rd_ff].row_end;
   assign rsp_frame_end     = out_ff[out_rd_ff].frame_end;

   assign status.out_count = out_count_ff;
   assign status.inflight  = 2'(b_emit) + 2'(c_valid_ff && c_emit_ff) + 2'(d_valid_ff);

endmodule

>>> sv/multigrid_restrict_2d.sv
// Top level of the 2D multigrid restriction block (4x4, weights 1-3-3-1).
// Depends on mgr2d_pkg, mgr2d_front, mgr2d_desc_fifo, mgr2d_back and the defines header.
//   Fine samples (signed Q16.16) are pushed in raster order on req_*; a word is
//   taken at a clock edge with req_push high and req_full low. The fine grid is
//   2*coarse_width by 2*coarse_height. Coarse cells come out in raster order on
//   rsp_*; the oldest one is shown while rsp_empty is low and is taken at an
//   edge with rsp_pop high. rsp_row_end marks the last cell of a coarse row,
//   rsp_frame_end the last cell of the grid.
//   The csr_* channel writes coarse_width (index 0) or coarse_height (index 1);
//   csr_ready is always high. Any write to either register restarts the frame.
//   Write only while no word is in flight.
// Timing:
//   One fine word per cycle, sustained while req_full stays low. The fine word
//   that completes a coarse cell passes through the word queue and the sum
//   pipeline (line buffer read, vertical sum, horizontal sum), then rounding
//   into the result queue, before the cell is visible on rsp_*.
// Reset and stall:
//   Reset sets both sizes to 512 and the position to the frame start. Line
//   buffers are not cleared; they are read only where this frame wrote them.
//   When the receiver stops popping, the eight-word result queue fills, the
//   back end stops taking words, and req_full rises once the four-word queue
//   between front and back end is full.
`include "multigrid_restrict_2d_defines.svh"

module multigrid_restrict_2d import mgr2d_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   input  sample_type                req_fine_sample,
   output logic                      req_full,
   output sample_type                rsp_coarse_sample,
   output logic                      rsp_row_end,
   output logic                      rsp_frame_end,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   desc_type                front_desc;
   logic                    front_push;
   desc_type                mid_head;
   logic                    mid_full;
   logic                    mid_empty;
   logic                    mid_pop;
   logic [MID_CNT_BITS-1:0] mid_count;
   front_status_type        front_status;
   back_status_type         back_status;

   // Front end: position tracking and classification of each fine word.
   mgr2d_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_fine_sample (req_fine_sample),
      .req_full        (req_full),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .csr_ready       (csr_ready),
      .desc_push       (front_push),
      .desc            (front_desc),
      .desc_full       (mid_full),
      .status          (front_status)
   );

   // Decoupling queue so the front end keeps taking words while the back
   // end waits for room in the result queue.
   mgr2d_desc_fifo u_mid (
      .clock (clock),
      .reset (reset),
      .push  (front_push),
      .din   (front_desc),
      .full  (mid_full),
      .pop   (mid_pop),
      .dout  (mid_head),
      .empty (mid_empty),
      .count (mid_count)
   );

   // Back end: line buffers, separable sums, rounding and result queue.
   mgr2d_back u_back (
      .clock             (clock),
      .reset             (reset),
      .desc              (mid_head),
      .desc_empty        (mid_empty),
      .desc_pop          (mid_pop),
      .rsp_coarse_sample (rsp_coarse_sample),
      .rsp_row_end       (rsp_row_end),
      .rsp_frame_end     (rsp_frame_end),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .status            (back_status)
   );

   // A register write puts the next fine word at the frame start.
   `MGR2D_ASSERT_NEXT(a_cfg_restart, clock, reset, csr_valid && csr_ready && (csr_index == CSR_COARSE_WIDTH || csr_index == CSR_COARSE_HEIGHT), front_status.col == '0 && front_status.row == '0)

   // Cells in the result queue plus those in the pipeline never exceed its depth.
   `MGR2D_ASSERT_IMPL(a_rsp_credit, clock, reset, 1'b1, (32'(back_status.out_count) + 32'(back_status.inflight)) <= OUT_DEPTH)

   // A taken fine word is in the middle queue at the next edge.
   `MGR2D_ASSERT_NEXT(a_mid_holds, clock, reset, req_push && !req_full, mid_count != '0)

   // The last cell of the grid is also the last cell of its row.
   `MGR2D_ASSERT_IMPL(a_frame_row_end, clock, reset, !rsp_empty && rsp_frame_end, rsp_row_end)

endmodule
